// ----- src/eased_ring_wipe_led_layer_defines.svh -----
// ----------------------------------------------------------------------------
// Ring wipe layer assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef EASED_RING_WIPE_LED_LAYER_DEFINES_SVH
`define EASED_RING_WIPE_LED_LAYER_DEFINES_SVH

// same-cycle implication
`define ERWL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ring wipe layer check failed");

// next-cycle implication
`define ERWL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ring wipe layer check failed");

`endif

// ----- src/erwl_pkg.sv -----
// ----------------------------------------------------------------------------
// Ring wipe layer package
// Widths, fixed-point constants, codes and transaction types of the layer.
// ----------------------------------------------------------------------------
package erwl_pkg;

   // sizing
   localparam int MAX_PIXELS = 1024;
   localparam int FRAC_BITS  = 16;
   localparam int FRAC_W     = FRAC_BITS + 1;
   localparam int LEN_W      = 11;
   localparam int DUR_W      = 16;
   localparam int COLOR_W    = 24;
   localparam int TIME_W     = 32;
   localparam int IDX_W      = 10;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int RINGS      = 4;

   // serial multiplier: multiplicand FRAC_W bits, multiplier MB_W bits
   localparam int MB_W   = (FRAC_W > LEN_W) ? FRAC_W : LEN_W;
   localparam int PROD_W = FRAC_W + MB_W;
   localparam int STEPS_MAX = (MB_W > FRAC_BITS) ? MB_W : FRAC_BITS;
   localparam int CNT_W  = $clog2(STEPS_MAX + 1);

   // fixed-point one and one half
   localparam logic [FRAC_W-1:0] ONE_VALUE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_W-1:0] HALF_VALUE = {2'b01, {(FRAC_BITS-1){1'b0}}};

   localparam logic [COLOR_W-1:0] COLOR_BLACK = '0;

   // opcodes
   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_ENABLE  = 2'd1;
   localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_TWO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_THREE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_FOUR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_COLOR    = 3'd5;

   // multiply sequence steps
   localparam logic [2:0] STEP_SQUARE = 3'd0;
   localparam logic [2:0] STEP_CUBE   = 3'd1;
   localparam logic [2:0] STEP_RING0  = 3'd2;
   localparam logic [2:0] STEP_RING3  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAMP,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [TIME_W-1:0] time_now_ms;
      logic [IDX_W-1:0]  pixel_index;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_rgb;
      logic               pixel_lit;
      logic               positions_changed;
      logic               layer_active;
   } rsp_type;

endpackage

// ----- src/eased_ring_wipe_led_layer.sv -----
// ----------------------------------------------------------------------------
// Eased ring wipe LED layer
// Four-ring on/off wipe with an in-out cubic ease and per-pixel color query.
// ----------------------------------------------------------------------------
// Usage
//   req channel (valid/ready) carries one transaction: tick with a millisecond
//   timestamp, enable, disable, or pixel query. Every transaction returns
//   exactly one response on the rsp channel (valid/ready).
//   csr channel writes a configuration register by index; it is always ready
//   and must only be used while the layer is idle.
// Sequencing
//   One transaction at a time. Enable, disable and query go from acceptance
//   through the finish state to the response register. A tick that leaves the
//   animation time unchanged passes through the ramp state first. A tick that
//   moves it also runs the serial divider and then six products on the
//   bit-serial multiplier (square, cube, four ring lengths); the divider is
//   skipped when the time fraction is exactly zero or one. All six products
//   share the one shift-add multiplier.
// Reset
//   Synchronous, active high: control and configuration registers return to
//   their defaults, animation time and ring lengths to zero, layer disabled,
//   no response pending.
// Stalls
//   The response is held in an output register until taken; the next request
//   is accepted meanwhile and waits in its last stage for the register.
`include "eased_ring_wipe_led_layer_defines.svh"

module eased_ring_wipe_led_layer
   import erwl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // control and state registers
   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [TIME_W-1:0]    last_tick_ff, last_tick_in;
   logic [DUR_W-1:0]     ramp_ff, ramp_in;
   logic                 turning_on_ff, turning_on_in;
   logic [LEN_W-1:0]     len_ff [RINGS];
   logic [LEN_W-1:0]     len_in [RINGS];
   logic                 changed_ff, changed_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [2:0]           step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [LEN_W-1:0]     pix_count_ff, pix_count_in;
   logic [LEN_W-1:0]     r2_ff, r2_in;
   logic [LEN_W-1:0]     r3_ff, r3_in;
   logic [LEN_W-1:0]     r4_ff, r4_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic [COLOR_W-1:0]   color_ff, color_in;

   // datapath registers
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [TIME_W-1:0]    delta_ff, delta_in;
   logic                 half_ff, half_in;
   logic [FRAC_W-1:0]    x_ff, x_in;
   logic [FRAC_W-1:0]    a_ff, a_in;
   logic [MB_W-1:0]      b_ff, b_in;
   logic [FRAC_W-1:0]    hi_ff, hi_in;
   logic [MB_W-1:0]      lo_ff, lo_in;
   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   rsp_type              rsp_ff, rsp_in;

   // combinational helpers
   logic                 req_fire;
   logic                 start_cubic;
   logic [FRAC_W-1:0]    t_start;
   logic [FRAC_W:0]      u_wide;
   logic                 load_mul;
   logic [FRAC_W-1:0]    mul_a;
   logic [MB_W-1:0]      mul_b;
   logic [FRAC_W:0]      mul_sum;
   logic [PROD_W-1:0]    prod;
   logic [FRAC_W-1:0]    prod_frac;
   logic [LEN_W-1:0]     prod_len;
   logic [FRAC_W-1:0]    e_in;
   logic [DUR_W:0]       rem_dbl;
   logic [DUR_W:0]       ramp_sum;
   logic [LEN_W-1:0]     count_clamped;
   logic [LEN_W-1:0]     span [RINGS];
   logic [1:0]           ring_k;
   logic [1:0]           ring_next;
   logic [LEN_W-1:0]     idx_w;
   logic                 pixel_on;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign req_fire  = req_valid && req_ready;

   // ring spans from the configured starts
   always_comb begin
      count_clamped = (int'(pix_count_ff) > MAX_PIXELS) ? LEN_W'(MAX_PIXELS) : pix_count_ff;
      span[0] = r2_ff;
      span[1] = (r3_ff > r2_ff) ? (r3_ff - r2_ff) : '0;
      span[2] = (r4_ff > r3_ff) ? (r4_ff - r3_ff) : '0;
      span[3] = (count_clamped > r4_ff) ? (count_clamped - r4_ff) : '0;
   end

   // multiplier product taps
   assign prod      = {hi_ff, lo_ff};
   assign prod_frac = prod[FRAC_BITS +: FRAC_W];
   assign prod_len  = prod[FRAC_BITS +: LEN_W];
   assign mul_sum   = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : '0);
   assign ring_k    = 2'(step_ff - STEP_RING0);
   assign ring_next = ring_k + 2'd1;
   assign rem_dbl   = {rem_ff, 1'b0};
   assign ramp_sum  = {1'b0, ramp_ff} + {1'b0, delta_ff[DUR_W-1:0]};

   // pixel lookup against the current lit prefixes
   always_comb begin
      idx_w = LEN_W'(idx_ff);
      if (idx_w < r2_ff) begin
         pixel_on = idx_w < len_ff[0];
      end else if (idx_w < r3_ff) begin
         pixel_on = (idx_w - r2_ff) < len_ff[1];
      end else if (idx_w < r4_ff) begin
         pixel_on = (idx_w - r3_ff) < len_ff[2];
      end else begin
         pixel_on = (idx_w - r4_ff) < len_ff[3];
      end
   end

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      last_tick_in  = last_tick_ff;
      ramp_in       = ramp_ff;
      turning_on_in = turning_on_ff;
      len_in        = len_ff;
      changed_in    = changed_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      idx_in        = idx_ff;
      delta_in      = delta_ff;
      half_in       = half_ff;
      x_in          = x_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      rsp_in        = rsp_ff;
      start_cubic   = 1'b0;
      t_start       = '0;
      load_mul      = 1'b0;
      mul_a         = a_ff;
      mul_b         = '0;
      e_in          = '0;
      u_wide        = '0;

      case (state_ff)
         // take a transaction
         ST_IDLE: begin
            if (req_fire) begin
               op_in      = req_data.opcode;
               idx_in     = req_data.pixel_index;
               changed_in = 1'b0;
               case (req_data.opcode)
                  OP_TICK: begin
                     last_tick_in = req_data.time_now_ms;
                     delta_in     = req_data.time_now_ms - last_tick_ff;
                     state_in     = ST_RAMP;
                  end
                  OP_ENABLE: begin
                     turning_on_in = 1'b1;
                     state_in      = ST_FINISH;
                  end
                  OP_DISABLE: begin
                     turning_on_in = 1'b0;
                     state_in      = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // move animation time, saturating at both ends
         ST_RAMP: begin
            state_in = ST_FINISH;
            if (turning_on_ff) begin
               if (ramp_ff != dur_ff) begin
                  if ((delta_ff[TIME_W-1:DUR_W] != '0) || (ramp_sum > {1'b0, dur_ff})) begin
                     ramp_in = dur_ff;
                  end else begin
                     ramp_in = ramp_sum[DUR_W-1:0];
                  end
                  state_in = ST_PREP;
               end
            end else if (ramp_ff != '0) begin
               if ((delta_ff[TIME_W-1:DUR_W] == '0) && (ramp_ff > delta_ff[DUR_W-1:0])) begin
                  ramp_in = ramp_ff - delta_ff[DUR_W-1:0];
               end else begin
                  ramp_in = '0;
               end
               state_in = ST_PREP;
            end
         end

         // pick the time fraction or start the divider
         ST_PREP: begin
            if (ramp_ff == '0) begin
               start_cubic = 1'b1;
               t_start     = '0;
            end else if (ramp_ff >= dur_ff) begin
               start_cubic = 1'b1;
               t_start     = ONE_VALUE;
            end else begin
               rem_in   = ramp_ff;
               quo_in   = '0;
               cnt_in   = CNT_W'(FRAC_BITS);
               state_in = ST_DIV;
            end
         end

         // restoring divide, one quotient bit per cycle
         ST_DIV: begin
            if (cnt_ff != '0) begin
               if (rem_dbl >= {1'b0, dur_ff}) begin
                  rem_in = DUR_W'(rem_dbl - {1'b0, dur_ff});
                  quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
               end else begin
                  rem_in = rem_dbl[DUR_W-1:0];
                  quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
               end
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               start_cubic = 1'b1;
               t_start     = {1'b0, quo_ff};
            end
         end

         // shift-add multiply, then consume the product
         ST_MUL: begin
            if (cnt_ff != '0) begin
               hi_in  = mul_sum[FRAC_W:1];
               lo_in  = {mul_sum[0], lo_ff[MB_W-1:1]};
               b_in   = b_ff >> 1;
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               case (step_ff)
                  STEP_SQUARE: begin
                     load_mul = 1'b1;
                     mul_a    = x_ff;
                     mul_b    = MB_W'(prod_frac);
                     step_in  = STEP_CUBE;
                  end
                  STEP_CUBE: begin
                     if (half_ff) begin
                        e_in = {prod_frac[FRAC_W-3:0], 2'b00};
                     end else begin
                        e_in = ONE_VALUE - (prod_frac >> 1);
                     end
                     load_mul = 1'b1;
                     mul_a    = e_in;
                     mul_b    = MB_W'(span[0]);
                     step_in  = STEP_RING0;
                  end
                  default: begin
                     if (prod_len != len_ff[ring_k]) begin
                        changed_in = 1'b1;
                     end
                     len_in[ring_k] = prod_len;
                     if (step_ff == STEP_RING3) begin
                        state_in = ST_FINISH;
                     end else begin
                        load_mul = 1'b1;
                        mul_a    = a_ff;
                        mul_b    = MB_W'(span[ring_next]);
                        step_in  = step_ff + 3'd1;
                     end
                  end
               endcase
            end
         end

         // hand the response to the output register
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.pixel_lit         = (op_ff == OP_QUERY) && pixel_on;
               rsp_in.pixel_rgb         = ((op_ff == OP_QUERY) && pixel_on) ? color_ff
                                                                            : COLOR_BLACK;
               rsp_in.positions_changed = changed_ff;
               rsp_in.layer_active      = (ramp_ff != '0);
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // ease setup: fold the upper half onto u = 2 - 2t
      if (start_cubic) begin
         u_wide  = {ONE_VALUE, 1'b0} - {t_start, 1'b0};
         half_in = (t_start < HALF_VALUE);
         x_in    = half_in ? t_start : u_wide[FRAC_W-1:0];
         load_mul = 1'b1;
         mul_a    = x_in;
         mul_b    = MB_W'(x_in);
         step_in  = STEP_SQUARE;
      end

      // multiplier load
      if (load_mul) begin
         a_in     = mul_a;
         b_in     = mul_b;
         hi_in    = '0;
         lo_in    = '0;
         cnt_in   = CNT_W'(MB_W);
         state_in = ST_MUL;
      end
   end

   // configuration writes
   always_comb begin
      pix_count_in = pix_count_ff;
      r2_in        = r2_ff;
      r3_in        = r3_ff;
      r4_in        = r4_ff;
      dur_in       = dur_ff;
      color_in     = color_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_COUNT: pix_count_in = csr_data[LEN_W-1:0];
            CSR_RING_TWO:    r2_in        = csr_data[LEN_W-1:0];
            CSR_RING_THREE:  r3_in        = csr_data[LEN_W-1:0];
            CSR_RING_FOUR:   r4_in        = csr_data[LEN_W-1:0];
            CSR_DURATION:    dur_in       = csr_data[DUR_W-1:0];
            CSR_ON_COLOR:    color_in     = csr_data[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control, state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_TICK;
         last_tick_ff  <= '0;
         ramp_ff       <= '0;
         turning_on_ff <= 1'b0;
         for (int k = 0; k < RINGS; k++) begin
            len_ff[k] <= '0;
         end
         changed_ff    <= 1'b0;
         cnt_ff        <= '0;
         step_ff       <= STEP_SQUARE;
         rsp_valid_ff  <= 1'b0;
         pix_count_ff  <= LEN_W'(1024);
         r2_ff         <= LEN_W'(256);
         r3_ff         <= LEN_W'(512);
         r4_ff         <= LEN_W'(768);
         dur_ff        <= DUR_W'(1000);
         color_ff      <= {COLOR_W{1'b1}};
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         last_tick_ff  <= last_tick_in;
         ramp_ff       <= ramp_in;
         turning_on_ff <= turning_on_in;
         len_ff        <= len_in;
         changed_ff    <= changed_in;
         cnt_ff        <= cnt_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         pix_count_ff  <= pix_count_in;
         r2_ff         <= r2_in;
         r3_ff         <= r3_in;
         r4_ff         <= r4_in;
         dur_ff        <= dur_in;
         color_ff      <= color_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      delta_ff <= delta_in;
      half_ff  <= half_in;
      x_ff     <= x_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rsp_ff   <= rsp_in;
   end

   // checks
   `ERWL_ASSERT_NEXT(a_ramp_capped, (state_ff == ST_RAMP) && turning_on_ff, ramp_ff <= $past(dur_ff))
   `ERWL_ASSERT_NOW(a_ease_in_range, 1'b1, e_in <= ONE_VALUE)
   `ERWL_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   `ERWL_ASSERT_NOW(a_rsp_kind, rsp_valid_ff, !(rsp_ff.pixel_lit && rsp_ff.positions_changed))

endmodule

// ----- verif/tb_eased_ring_wipe_led_layer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring wipe layer testbench
// Sends tick, enable, disable and pixel query transactions through the layer
// under random handshake stalls. A fixed-point model of the eased wipe
// predicts each response when its request is taken, and every response is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_eased_ring_wipe_led_layer;
   import erwl_pkg::*;

   // dut ports, inputs driven from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // register mirror, reset values
   logic [LEN_W-1:0]   cfg_pixel_count = 11'd1024;
   logic [LEN_W-1:0]   cfg_ring_two    = 11'd256;
   logic [LEN_W-1:0]   cfg_ring_three  = 11'd512;
   logic [LEN_W-1:0]   cfg_ring_four   = 11'd768;
   logic [DUR_W-1:0]   cfg_duration    = 16'd1000;
   logic [COLOR_W-1:0] cfg_on_color    = 24'hFFFFFF;

   // wipe state mirror
   logic [TIME_W-1:0] lay_last_tick  = '0;
   logic [DUR_W-1:0]  lay_ramp_time  = '0;
   logic              lay_turning_on = 1'b0;
   logic [LEN_W-1:0]  lay_lit_len [RINGS] = '{default: '0};

   // responses predicted but not yet seen
   rsp_type pending_rsp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int n_sent        = 0;
   int n_checked     = 0;
   int n_moved       = 0;
   int n_lit         = 0;
   int n_writes      = 0;

   always #5 clock = ~clock;

   eased_ring_wipe_led_layer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // in-out cubic of ramp time over duration, Q1.16
   function automatic longint unsigned eased_level();
      longint unsigned one, t, t2, t3, u, u2, u3, h, e;
      one = 64'd1 << FRAC_BITS;
      if (lay_ramp_time == 0)
         t = 0;
      else if (lay_ramp_time >= cfg_duration)
         t = one;
      else
         t = (64'(lay_ramp_time) << FRAC_BITS) / 64'(cfg_duration);
      if (t > one)
         t = one;
      if (t < (one >> 1)) begin
         t2 = (t * t) >> FRAC_BITS;
         t3 = (t2 * t) >> FRAC_BITS;
         e  = 4 * t3;
      end else begin
         u  = 2 * one - 2 * t;
         u2 = (u * u) >> FRAC_BITS;
         u3 = (u2 * u) >> FRAC_BITS;
         h  = u3 >> 1;
         e  = (h > one) ? 0 : one - h;
      end
      return (e > one) ? one : e;
   endfunction

   // scale each ring span by the eased level, flag any change
   function automatic bit refresh_lit_lengths();
      int unsigned     count;
      int unsigned     spans [RINGS];
      longint unsigned e;
      logic [LEN_W-1:0] len;
      bit              changed;
      count = (cfg_pixel_count > MAX_PIXELS) ? MAX_PIXELS : cfg_pixel_count;
      e = eased_level();
      // negative spans from unordered starts count as empty
      spans[0] = cfg_ring_two;
      spans[1] = (cfg_ring_three > cfg_ring_two) ? cfg_ring_three - cfg_ring_two : 0;
      spans[2] = (cfg_ring_four > cfg_ring_three) ? cfg_ring_four - cfg_ring_three : 0;
      spans[3] = (count > cfg_ring_four) ? count - cfg_ring_four : 0;
      changed = 1'b0;
      for (int k = 0; k < RINGS; k++) begin
         len = LEN_W'((e * spans[k]) >> FRAC_BITS);
         if (len != lay_lit_len[k]) begin
            lay_lit_len[k] = len;
            changed = 1'b1;
         end
      end
      return changed;
   endfunction

   // pixel lies inside the lit prefix of its ring
   function automatic bit pixel_shows_color(input logic [IDX_W-1:0] idx);
      int unsigned i;
      i = idx;
      if (i < cfg_ring_two)
         return i < lay_lit_len[0];
      if (i < cfg_ring_three)
         return (i - cfg_ring_two) < lay_lit_len[1];
      if (i < cfg_ring_four)
         return (i - cfg_ring_three) < lay_lit_len[2];
      return (i - cfg_ring_four) < lay_lit_len[3];
   endfunction

   // advance the mirror by one request and return its response
   function automatic rsp_type predict_response(input req_type item);
      rsp_type           r;
      logic [TIME_W-1:0] delta;
      longint unsigned   sum;
      bit                moved;
      r = '0;
      moved = 1'b0;
      case (item.opcode)
         OP_TICK: begin
            // wrap-safe elapsed time since the previous tick
            delta = item.time_now_ms - lay_last_tick;
            lay_last_tick = item.time_now_ms;
            if (lay_turning_on) begin
               if (lay_ramp_time != cfg_duration) begin
                  sum = 64'(lay_ramp_time) + 64'(delta);
                  lay_ramp_time = (sum > cfg_duration) ? cfg_duration : DUR_W'(sum);
                  moved = 1'b1;
               end
            end else if (lay_ramp_time != 0) begin
               lay_ramp_time = (lay_ramp_time > delta) ? DUR_W'(lay_ramp_time - delta) : '0;
               moved = 1'b1;
            end
            if (moved)
               r.positions_changed = refresh_lit_lengths();
         end
         OP_ENABLE:  lay_turning_on = 1'b1;
         OP_DISABLE: lay_turning_on = 1'b0;
         default: begin
            if (pixel_shows_color(item.pixel_index)) begin
               r.pixel_rgb = cfg_on_color;
               r.pixel_lit = 1'b1;
            end
         end
      endcase
      r.layer_active = (lay_ramp_time != 0);
      return r;
   endfunction

   function automatic req_type make_req(input logic [OP_W-1:0] op,
                                        input logic [TIME_W-1:0] stamp,
                                        input logic [IDX_W-1:0] idx);
      req_type item;
      item.opcode      = op;
      item.time_now_ms = stamp;
      item.pixel_index = idx;
      return item;
   endfunction

   // query target: half the time around a ring's lit edge, else inside or anywhere
   function automatic logic [IDX_W-1:0] pick_pixel();
      int unsigned sel, ring, base, count;
      sel = $urandom_range(3);
      count = (cfg_pixel_count > MAX_PIXELS) ? MAX_PIXELS : cfg_pixel_count;
      if (sel < 2) begin
         ring = $urandom_range(RINGS - 1);
         base = (ring == 0) ? 0 : (ring == 1) ? cfg_ring_two :
                (ring == 2) ? cfg_ring_three : cfg_ring_four;
         return IDX_W'(base + lay_lit_len[ring] + $urandom_range(2) - 1);
      end
      if (sel == 2 && count != 0)
         return IDX_W'($urandom_range(count - 1));
      return IDX_W'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------

   // one request transaction; valid stays up into the next one when no gap
   task automatic send_item(input req_type item);
      rsp_type r;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      r = predict_response(item);
      pending_rsp.push_back(r);
      n_sent++;
      n_moved += r.positions_changed;
      n_lit   += r.pixel_lit;
   endtask

   // hold off requests until every response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_PIXEL_COUNT: cfg_pixel_count = value[LEN_W-1:0];
         CSR_RING_TWO:    cfg_ring_two    = value[LEN_W-1:0];
         CSR_RING_THREE:  cfg_ring_three  = value[LEN_W-1:0];
         CSR_RING_FOUR:   cfg_ring_four   = value[LEN_W-1:0];
         CSR_DURATION:    cfg_duration    = value[DUR_W-1:0];
         CSR_ON_COLOR:    cfg_on_color    = value[COLOR_W-1:0];
         default: ;
      endcase
      n_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] count,
                                 input logic [CSR_DATA_W-1:0] two,
                                 input logic [CSR_DATA_W-1:0] three,
                                 input logic [CSR_DATA_W-1:0] four,
                                 input logic [CSR_DATA_W-1:0] dur,
                                 input logic [CSR_DATA_W-1:0] color);
      wait_idle();
      write_register(CSR_PIXEL_COUNT, count);
      write_register(CSR_RING_TWO, two);
      write_register(CSR_RING_THREE, three);
      write_register(CSR_RING_FOUR, four);
      write_register(CSR_DURATION, dur);
      write_register(CSR_ON_COLOR, color);
   endtask

   // response side stalls
   always @(posedge clock)
      rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch on %s at response %0d: expected %0h, got %0h",
               field, n_checked, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", '0, 32'(rsp_data));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.pixel_rgb !== want.pixel_rgb)
               report_mismatch("pixel_rgb", want.pixel_rgb, rsp_data.pixel_rgb);
            if (rsp_data.pixel_lit !== want.pixel_lit)
               report_mismatch("pixel_lit", want.pixel_lit, rsp_data.pixel_lit);
            if (rsp_data.positions_changed !== want.positions_changed)
               report_mismatch("positions_changed", want.positions_changed,
                               rsp_data.positions_changed);
            if (rsp_data.layer_active !== want.layer_active)
               report_mismatch("layer_active", want.layer_active, rsp_data.layer_active);
            n_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // nothing lit and nothing moving right after reset
   task automatic test_quiet_after_reset();
      send_item(make_req(OP_QUERY, '0, 10'd0));
      send_item(make_req(OP_QUERY, '1, 10'd1023));
      send_item(make_req(OP_TICK, 32'd0, '1));
   endtask

   // half wipe, full wipe, idle tick at full, then back to dark
   task automatic test_full_wipe();
      send_item(make_req(OP_ENABLE, '0, '0));
      send_item(make_req(OP_TICK, 32'd500, '0));
      send_item(make_req(OP_QUERY, '0, 10'd127));
      send_item(make_req(OP_QUERY, '0, 10'd128));
      send_item(make_req(OP_TICK, 32'd1700, '0));
      send_item(make_req(OP_TICK, 32'd1700, '0));
      send_item(make_req(OP_QUERY, '0, 10'd1023));
      send_item(make_req(OP_DISABLE, '0, '0));
      send_item(make_req(OP_TICK, 32'hFFFF_FFF0, '0));
   endtask

   // timestamp rolls over between two ticks
   task automatic test_time_wrap();
      send_item(make_req(OP_ENABLE, '0, '0));
      send_item(make_req(OP_TICK, 32'h0000_0010, '0));
      send_item(make_req(OP_TICK, 32'h0000_0190, '0));
   endtask

   // zero duration, unordered starts, pixels past the count, duration under ramp
   task automatic test_register_corners();
      send_item(make_req(OP_DISABLE, '0, '0));
      wait_idle();
      // nonzero ramp time with zero duration reads as fully on
      write_register(CSR_DURATION, 24'd0);
      write_register(CSR_ON_COLOR, 24'h5AA55A);
      send_item(make_req(OP_TICK, 32'h0000_019A, '0));
      send_item(make_req(OP_QUERY, '0, 10'd10));
      wait_idle();
      // ring three starts before ring two, count ends before ring four
      write_register(CSR_PIXEL_COUNT, 24'd700);
      write_register(CSR_RING_TWO, 24'd600);
      write_register(CSR_RING_THREE, 24'd200);
      write_register(CSR_RING_FOUR, 24'd900);
      write_register(CSR_DURATION, 24'd65535);
      // lengths stay as they were until a tick moves the ramp
      send_item(make_req(OP_QUERY, '0, 10'd650));
      send_item(make_req(OP_ENABLE, '0, '0));
      send_item(make_req(OP_TICK, 32'h0000_019A + 32'd30000, '0));
      send_item(make_req(OP_QUERY, '0, 10'd100));
      send_item(make_req(OP_QUERY, '0, 10'd950));
      wait_idle();
      // duration shorter than current ramp time clamps it
      write_register(CSR_DURATION, 24'd100);
      send_item(make_req(OP_TICK, 32'h0000_019A + 32'd30000, '0));
      send_item(make_req(OP_QUERY, '0, 10'd650));
   endtask

   // mostly coherent wipes with random content, some noise
   task automatic run_traffic(input int n_items);
      int unsigned pick, span, step;
      req_type     item;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         item.opcode      = OP_QUERY;
         item.time_now_ms = $urandom;
         item.pixel_index = IDX_W'($urandom);
         if (pick < 8) begin
            item.opcode = OP_W'($urandom_range(3));
         end else if (pick < 18) begin
            item.opcode = ($urandom_range(99) < 55) ? OP_ENABLE : OP_DISABLE;
         end else if (pick < 58) begin
            // steps scaled to the duration so ramps cross the whole curve
            span = (cfg_duration == 0) ? 4 : cfg_duration;
            if ($urandom_range(9) == 0)
               step = $urandom_range(span * 2, span);
            else
               step = $urandom_range(span / 3 + 1);
            item.opcode      = OP_TICK;
            item.time_now_ms = lay_last_tick + step;
         end else begin
            item.pixel_index = pick_pixel();
         end
         send_item(item);
         if ($urandom_range(199) == 0)
            wait_idle();
      end
   endtask

   task automatic choose_settings(input int which);
      int unsigned two, three, four;
      case (which)
         0: apply_settings(24'd1024, 24'd256, 24'd512, 24'd768, 24'd1000, 24'hFFFFFF);
         1: apply_settings(24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'h000000);
         2: apply_settings(24'd2047, 24'd2047, 24'd2047, 24'd2047, 24'd65535, 24'hFFFFFF);
         3: begin
            two   = $urandom_range(300);
            three = two + $urandom_range(300);
            four  = three + $urandom_range(300);
            apply_settings(four + $urandom_range(150, 1), two, three, four,
                           $urandom_range(2000, 1), $urandom);
         end
         default: begin
            apply_settings($urandom_range(2047), $urandom_range(1100), $urandom_range(1100),
                           $urandom_range(1100),
                           ($urandom_range(3) == 0) ? 0 : $urandom_range(5000, 1),
                           $urandom);
         end
      endcase
   endtask

   // three stall patterns, each over every ring layout
   task automatic test_random_wipes();
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 55 : 0;
         recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 25 : 0;
         for (int s = 0; s < 5; s++) begin
            choose_settings(s);
            run_traffic(92);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      send_idle_pct = 25;
      recv_idle_pct = 55;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_quiet_after_reset();
      test_full_wipe();
      test_time_wrap();
      test_register_corners();
      test_random_wipes();
      wait_idle();
      // room for a stray late response
      repeat (140) @(posedge clock);
      $display("ring wipe run: %0d transactions checked, %0d ticks moved rings, %0d pixels lit",
               n_checked, n_moved, n_lit);
      $display("%0d register writes over default, minimal, maximal and random ring layouts",
               n_writes);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
